// ===== src/ctc_pkg.sv =====
// shared types and constants of the checkpoint table checker
package ctc_pkg;

  localparam int unsigned HEIGHT_W = 64;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned HASH_W   = 4 * WORD_W;
  localparam int unsigned COUNT_W  = 7;

  // request codes
  localparam logic [1:0] REQ_INSERT    = 2'd0;
  localparam logic [1:0] REQ_CHECK     = 2'd1;
  localparam logic [1:0] REQ_ALT_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [HEIGHT_W-1:0] height;
    logic [HEIGHT_W-1:0] chain_height;
    logic [WORD_W-1:0]   hash_word0;
    logic [WORD_W-1:0]   hash_word1;
    logic [WORD_W-1:0]   hash_word2;
    logic [WORD_W-1:0]   hash_word3;
  } req_t;

  typedef struct packed {
    logic                result_ok;
    logic                full_flag;
    logic                is_checkpoint;
    logic                in_zone;
    logic [HEIGHT_W-1:0] max_height;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

endpackage

// ===== src/ctc_if.sv =====
// request and result channel interfaces of the checkpoint table checker
interface ctc_req_if;
  logic          valid;
  logic          ready;
  ctc_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ctc_rsp_if;
  logic          valid;
  logic          ready;
  ctc_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/ctc_ram.sv =====
// generic single-write, single-read ram with registered read data
module ctc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/checkpoint_table_checker_unit.sv =====
// top level of the checkpoint table checker: sequencer around height and hash memories
// each request scans the height and hash memories before its result is written,
//   one entry per cycle through their read port; a finished result may wait
//   in the output register while the next request is taken and scanned
// reset: entry count and highest height clear at once, the table starts empty
module checkpoint_table_checker_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ctc_req_if.sink        req_i,
  ctc_rsp_if.source      rsp_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e state_q;

  // table status
  logic [CW-1:0]                   count_q;
  logic [ctc_pkg::HEIGHT_W-1:0]    highest_q;

  // scan control and running results
  logic [CW-1:0]                   issue_idx_q;
  logic                            pend_q;
  logic                            found_q;
  logic                            hash_eq_q;
  logic                            best_vld_q;
  logic [ctc_pkg::HEIGHT_W-1:0]    best_q;

  // latched request
  logic [1:0]                      type_q;
  logic [ctc_pkg::HEIGHT_W-1:0]    height_q;
  logic [ctc_pkg::HEIGHT_W-1:0]    chain_q;
  logic [ctc_pkg::HASH_W-1:0]      hash_q;

  // output register
  logic                            out_vld_q;
  ctc_pkg::rsp_t                   out_q;

  // memory ports
  logic                            mem_we;
  logic [ctc_pkg::HEIGHT_W-1:0]    rd_height;
  logic [ctc_pkg::HASH_W-1:0]      rd_hash;

  // finish-step results
  logic                            fin_ok;
  logic                            fin_full;
  logic                            fin_append;
  logic [CW-1:0]                   count_d;
  logic [ctc_pkg::HEIGHT_W-1:0]    highest_d;
  logic                            out_free;
  logic                            fin_fire;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

  // output slot can take a new result this cycle
  assign out_free = !out_vld_q || rsp_o.ready;
  assign fin_fire = (state_q == ST_FIN) && out_free;
  assign mem_we   = fin_fire && fin_append;

  ctc_ram #(
    .WIDTH (ctc_pkg::HEIGHT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (height_q),
    .raddr_i (issue_idx_q[AW-1:0]),
    .rdata_o (rd_height)
  );

  ctc_ram #(
    .WIDTH (ctc_pkg::HASH_W),
    .DEPTH (TABLE_DEPTH)
  ) u_hash_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (hash_q),
    .raddr_i (issue_idx_q[AW-1:0]),
    .rdata_o (rd_hash)
  );

  // decide the request once the scan has seen every stored entry
  always_comb begin
    fin_ok     = 1'b0;
    fin_full   = 1'b0;
    fin_append = 1'b0;
    case (type_q)
      ctc_pkg::REQ_INSERT: begin
        if (found_q) begin
          // same height: accepted only with the same hash
          fin_ok = hash_eq_q;
        end else if (count_q >= CW'(TABLE_DEPTH)) begin
          fin_full = 1'b1;
        end else begin
          fin_ok     = 1'b1;
          fin_append = 1'b1;
        end
      end
      ctc_pkg::REQ_CHECK: begin
        fin_ok = !found_q || hash_eq_q;
      end
      ctc_pkg::REQ_ALT_QUERY: begin
        // refused at block height zero, else the nearest checkpoint must lie below
        fin_ok = (height_q != '0) && (!best_vld_q || (best_q < height_q));
      end
      default: begin
        fin_ok = 1'b0;
      end
    endcase

    count_d   = count_q;
    highest_d = highest_q;
    if (fin_append) begin
      count_d = CW'(count_q + 1'b1);
      if ((count_q == '0) || (height_q > highest_q)) begin
        highest_d = height_q;
      end
    end
  end

  // sequencer, table status and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      highest_q   <= '0;
      issue_idx_q <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      hash_eq_q   <= 1'b0;
      best_vld_q  <= 1'b0;
      best_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      // a new result fills the slot, else a taken result leaves it
      if (fin_fire) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.valid && rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            issue_idx_q <= '0;
            pend_q      <= 1'b0;
            found_q     <= 1'b0;
            hash_eq_q   <= 1'b0;
            best_vld_q  <= 1'b0;
            state_q     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // compare the entry read in the previous cycle
          if (pend_q) begin
            if (rd_height == height_q) begin
              found_q   <= 1'b1;
              hash_eq_q <= (rd_hash == hash_q);
            end
            if ((rd_height <= chain_q) && (!best_vld_q || (rd_height > best_q))) begin
              best_q     <= rd_height;
              best_vld_q <= 1'b1;
            end
          end
          // issue the next read, or finish once the last read is compared
          if (issue_idx_q < count_q) begin
            issue_idx_q <= CW'(issue_idx_q + 1'b1);
            pend_q      <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          // wait here while an older result still holds the output register
          if (out_free) begin
            count_q   <= count_d;
            highest_q <= highest_d;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // request latch and result payload
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      type_q   <= req_i.payload.req_type;
      height_q <= req_i.payload.height;
      chain_q  <= req_i.payload.chain_height;
      hash_q   <= {req_i.payload.hash_word3, req_i.payload.hash_word2,
                   req_i.payload.hash_word1, req_i.payload.hash_word0};
    end
    if (fin_fire) begin
      out_q.result_ok     <= fin_ok;
      out_q.full_flag     <= fin_full;
      out_q.is_checkpoint <= found_q || fin_append;
      out_q.in_zone       <= (count_d != '0) && (height_q <= highest_d);
      out_q.max_height    <= highest_d;
      out_q.entry_count   <= ctc_pkg::COUNT_W'(count_d);
    end
  end

endmodule
